### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

### hdl/toil_pkg.sv
`default_nettype none

package toil_pkg;

	localparam int COEF_W    = 40;
	localparam int COEF_FRAC = 36;
	localparam int NUM_TAPS  = 7;
	localparam int TAP_W     = 3;
	localparam int STEP_W    = 32;
	localparam int FSEL_W    = 3;

	localparam logic [STEP_W-1:0] STEP_ONE      = 32'h0001_0000;
	localparam logic [FSEL_W-1:0] FSEL_RESET    = 3'd2;
	localparam logic [2:0]        PRIME_SAMPLES = 3'd4;

	// configuration register indexes
	localparam logic REG_FILTER_SELECT  = 1'b0;
	localparam logic REG_PRECISION_STEP = 1'b1;

	typedef enum logic [1:0] {
		KIND_PRIME  = 2'd0,
		KIND_FILTER = 2'd1,
		KIND_PASS   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] set;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// per set: a1, a2, a3, b0, b1 as mantissa / 10^dec
	localparam longint unsigned COEF_MANT [4][5] = '{
		'{64'd273629493116515, 64'd250622421122369, 64'd767907452390706,
		  64'd252728458479901, 64'd758185375439702},
		'{64'd225008508172639, 64'd175640138178595, 64'd468312111171712,
		  64'd475052361098088, 64'd142515708329427},
		'{64'd291204248342765, 64'd28279107470461, 64'd91578680426307,
		  64'd101824194213562, 64'd305472582640687},
		'{64'd274883580921468, 64'd252823121914256, 64'd77763856023808,
		  64'd219606211225409, 64'd658818633676228}
	};
	localparam int COEF_DEC [4][5] = '{
		'{14, 14, 15, 18, 18},
		'{14, 14, 15, 17, 16},
		'{14, 13, 14, 19, 19},
		'{14, 14, 14, 18, 18}
	};
	localparam bit COEF_NEG [4][5] = '{
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0}
	};

	// decimal to Q3.36, magnitude rounded half away from zero
	function automatic logic signed [COEF_W-1:0] coef_q(input int s, input int idx);
		longint unsigned d;
		longint unsigned q;
		longint unsigned r;
		logic signed [COEF_W-1:0] v;
		d = 64'd1;
		for (int i = 0; i < 20; i++)
			if (i < COEF_DEC[s][idx])
				d = d * 64'd10;
		q = 64'd0;
		r = COEF_MANT[s][idx];
		for (int i = 0; i < 8; i++)
			if (r >= d) begin
				r = r - d;
				q = q + 64'd1;
			end
		for (int i = 0; i < COEF_FRAC; i++)
			if (r >= d - r) begin
				r = r - (d - r);
				q = 2 * q + 64'd1;
			end else begin
				r = 2 * r;
				q = 2 * q;
			end
		if (r >= d - r)
			q = q + 64'd1;
		v = COEF_W'(q);
		return COEF_NEG[s][idx] ? -v : v;
	endfunction

	// tap order: x0, x1, x2, x3, y1, y2, y3
	function automatic logic signed [COEF_W-1:0] tap_coef(input int s, input int t);
		logic signed [COEF_W-1:0] c;
		if (t == 0 || t == 3)
			c = coef_q(s, 3);
		else if (t == 1 || t == 2)
			c = coef_q(s, 4);
		else
			c = -coef_q(s, t - 4);
		return c;
	endfunction

	localparam logic signed [COEF_W-1:0] TAP_TAB [4][NUM_TAPS] = '{
		'{tap_coef(0, 0), tap_coef(0, 1), tap_coef(0, 2), tap_coef(0, 3),
		  tap_coef(0, 4), tap_coef(0, 5), tap_coef(0, 6)},
		'{tap_coef(1, 0), tap_coef(1, 1), tap_coef(1, 2), tap_coef(1, 3),
		  tap_coef(1, 4), tap_coef(1, 5), tap_coef(1, 6)},
		'{tap_coef(2, 0), tap_coef(2, 1), tap_coef(2, 2), tap_coef(2, 3),
		  tap_coef(2, 4), tap_coef(2, 5), tap_coef(2, 6)},
		'{tap_coef(3, 0), tap_coef(3, 1), tap_coef(3, 2), tap_coef(3, 3),
		  tap_coef(3, 4), tap_coef(3, 5), tap_coef(3, 6)}
	};

endpackage

`default_nettype wire

### hdl/toil_front.sv
`default_nettype none

module toil_front #(
	parameter int SW = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [SW-1:0]                in_sample,
	input  wire logic [toil_pkg::FSEL_W-1:0]  fsel,
	input  wire toil_pkg::fifo_stat_t         stat,
	output logic                              push,
	output toil_pkg::cmd_t                    push_cmd,
	output logic [SW-1:0]                     push_sample,
	output logic                              primed
);

	logic [2:0] warm_q;

	assign in_ready    = !stat.full;
	assign push        = in_valid && !stat.full;
	assign push_sample = in_sample;
	assign primed      = (warm_q == toil_pkg::PRIME_SAMPLES);

	always_comb begin
		push_cmd.set = fsel[1:0];
		priority if (warm_q < toil_pkg::PRIME_SAMPLES)
			push_cmd.kind = toil_pkg::KIND_PRIME;
		else if (fsel[2])
			push_cmd.kind = toil_pkg::KIND_PASS;
		else
			push_cmd.kind = toil_pkg::KIND_FILTER;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (push && !primed) begin
			warm_q <= warm_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

### hdl/toil_fifo.sv
`default_nettype none

module toil_fifo #(
	parameter int W = 36
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output toil_pkg::fifo_stat_t stat
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign dout       = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= din;
	end

endmodule

`default_nettype wire

### hdl/toil_back.sv
`default_nettype none

module toil_back #(
	parameter int SW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire toil_pkg::fifo_stat_t stat,
	input  wire toil_pkg::cmd_t       cmd,
	input  wire logic [SW-1:0]        cmd_sample,
	output logic                      pop,
	output logic                      y_valid,
	input  wire logic                 y_ready,
	output logic [SW-1:0]             y_data
);

	localparam int NCH   = (SW + 15) / 16;
	localparam int EXT_W = NCH * 16;
	localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PR_W  = toil_pkg::COEF_W + 17;
	localparam int ACC_W = toil_pkg::COEF_W + EXT_W + 3;
	localparam int TW    = ACC_W - toil_pkg::COEF_FRAC;

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_MAC   = 5'b00010,
		B_DRAIN = 5'b00100,
		B_ROUND = 5'b01000,
		B_SEND  = 5'b10000
	} bstate_t;

	bstate_t state_q;

	logic signed [SW-1:0] xh_q [3];
	logic signed [SW-1:0] yh_q [3];
	logic signed [SW-1:0] x0_q;
	logic [1:0]           set_q;
	logic [toil_pkg::TAP_W-1:0] tap_q;
	logic [CH_W-1:0]      chunk_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PR_W-1:0]  prod_s1;
	logic [CH_W-1:0]      chunk_s1;
	logic                 pvld_s1;
	logic [SW-1:0]        y_q;

	logic signed [SW-1:0]    op;
	logic signed [EXT_W-1:0] op_ext;
	logic [15:0]             seg;
	logic signed [16:0]      seg_s;
	logic signed [toil_pkg::COEF_W-1:0] coef;
	logic                    last_step;
	logic signed [ACC_W-1:0] rnd;
	logic signed [TW-1:0]    t;
	logic signed [SW-1:0]    y_rnd;

	assign pop     = (state_q == B_IDLE) && !stat.empty;
	assign y_valid = (state_q == B_SEND);
	assign y_data  = y_q;

	always_comb begin
		unique case (tap_q)
			3'd0:    op = x0_q;
			3'd1:    op = xh_q[0];
			3'd2:    op = xh_q[1];
			3'd3:    op = xh_q[2];
			3'd4:    op = yh_q[0];
			3'd5:    op = yh_q[1];
			3'd6:    op = yh_q[2];
			default: op = x0_q;
		endcase
		op_ext = EXT_W'(op);
		seg    = op_ext[16*chunk_q +: 16];
		// only the top 16-bit slice carries the sign
		seg_s  = (chunk_q == CH_W'(NCH - 1)) ? {seg[15], seg} : {1'b0, seg};
		coef   = toil_pkg::TAP_TAB[set_q][tap_q];
		last_step = (tap_q == toil_pkg::TAP_W'(toil_pkg::NUM_TAPS - 1)) &&
			(chunk_q == CH_W'(NCH - 1));
	end

	// round to Q16.16, halves rounded upward, then clamp
	always_comb begin
		rnd = acc_q + (ACC_W'(1) << (toil_pkg::COEF_FRAC - 1));
		t   = rnd[ACC_W-1:toil_pkg::COEF_FRAC];
		if (&t[TW-1:SW-1] || ~|t[TW-1:SW-1])
			y_rnd = t[SW-1:0];
		else if (t[TW-1])
			y_rnd = {1'b1, {(SW-1){1'b0}}};
		else
			y_rnd = {1'b0, {(SW-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pvld_s1 <= 1'b0;
			tap_q   <= '0;
			chunk_q <= '0;
			for (int i = 0; i < 3; i++) begin
				xh_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			pvld_s1 <= (state_q == B_MAC);
			unique case (state_q)
				B_IDLE: begin
					if (!stat.empty) begin
						unique case (cmd.kind)
							toil_pkg::KIND_PRIME: begin
								xh_q <= '{cmd_sample, xh_q[0], xh_q[1]};
								yh_q <= '{cmd_sample, yh_q[0], yh_q[1]};
							end
							toil_pkg::KIND_PASS: state_q <= B_SEND;
							toil_pkg::KIND_FILTER: begin
								tap_q   <= '0;
								chunk_q <= '0;
								state_q <= B_MAC;
							end
							default: ;
						endcase
					end
				end
				B_MAC: begin
					if (chunk_q == CH_W'(NCH - 1)) begin
						chunk_q <= '0;
						tap_q   <= tap_q + 3'd1;
					end else begin
						chunk_q <= chunk_q + CH_W'(1);
					end
					if (last_step)
						state_q <= B_DRAIN;
				end
				B_DRAIN: state_q <= B_ROUND;
				B_ROUND: begin
					xh_q    <= '{x0_q, xh_q[0], xh_q[1]};
					yh_q    <= '{y_rnd, yh_q[0], yh_q[1]};
					state_q <= B_SEND;
				end
				B_SEND: begin
					if (y_ready)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= coef * seg_s;
		chunk_s1 <= chunk_q;
		if (pop) begin
			x0_q  <= cmd_sample;
			set_q <= cmd.set;
			y_q   <= cmd_sample;
			acc_q <= '0;
		end else if (pvld_s1) begin
			acc_q <= acc_q + (ACC_W'(prod_s1) <<< {chunk_s1, 4'b0000});
		end
		if (state_q == B_ROUND)
			y_q <= y_rnd;
	end

endmodule

`default_nettype wire

### hdl/toil_quant.sv
`default_nettype none

module toil_quant #(
	parameter int SW = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         y_valid,
	output logic                              y_ready,
	input  wire logic [SW-1:0]                y_data,
	input  wire logic [toil_pkg::STEP_W-1:0]  step,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [SW-1:0]                     out_data
);

	localparam int NW    = ((SW > 32) ? SW : 32) + 2;
	localparam int DW    = toil_pkg::STEP_W + 1;
	localparam int CNT_W = $clog2(NW);

	typedef enum logic [3:0] {
		Q_IDLE = 4'b0001,
		Q_DIV  = 4'b0010,
		Q_FIN  = 4'b0100,
		Q_OUT  = 4'b1000
	} qstate_t;

	qstate_t state_q;

	logic [NW-1:0]    mag_q;
	logic [NW-1:0]    magk_q;
	logic             neg_q;
	logic [DW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    res_q;

	logic signed [SW-1:0] y;
	logic signed [SW-1:0] fl;
	logic signed [SW-1:0] tr;
	logic signed [NW-1:0] n;
	logic [DW-1:0]        den;
	logic [DW:0]          sh;
	logic [NW-1:0]        r;
	logic signed [NW-1:0] rs;
	logic [SW-1:0]        res_sat;

	assign y_ready   = (state_q == Q_IDLE);
	assign out_valid = (state_q == Q_OUT);
	assign out_data  = res_q;

	always_comb begin
		y   = y_data;
		// truncate toward zero to a whole number
		fl  = y & ~SW'(32'h0000_FFFF);
		tr  = fl + ((y[SW-1] && |(y & SW'(32'h0000_FFFF))) ? SW'(33'h1_0000) : SW'(0));
		n   = (NW'(y) <<< 1) + NW'($signed({1'b0, step}));
		den = {step, 1'b0};
		sh  = {rem_q, mag_q[NW-1]};
		// q * step equals (|n| - remainder) / 2
		r   = (magk_q - NW'(rem_q)) >> 1;
		rs  = neg_q ? -$signed(r) : $signed(r);
		if (&rs[NW-1:SW-1] || ~|rs[NW-1:SW-1])
			res_sat = rs[SW-1:0];
		else if (rs[NW-1])
			res_sat = {1'b1, {(SW-1){1'b0}}};
		else
			res_sat = {1'b0, {(SW-1){1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Q_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				Q_IDLE: begin
					if (y_valid) begin
						cnt_q <= '0;
						if (step == '0 || step == toil_pkg::STEP_ONE)
							state_q <= Q_OUT;
						else
							state_q <= Q_DIV;
					end
				end
				Q_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NW - 1))
						state_q <= Q_FIN;
				end
				Q_FIN: state_q <= Q_OUT;
				Q_OUT: begin
					if (out_ready)
						state_q <= Q_IDLE;
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			Q_IDLE: begin
				res_q  <= (step == toil_pkg::STEP_ONE) ? tr : y;
				neg_q  <= n[NW-1];
				mag_q  <= n[NW-1] ? NW'(-n) : NW'(n);
				magk_q <= n[NW-1] ? NW'(-n) : NW'(n);
				rem_q  <= '0;
			end
			Q_DIV: begin
				mag_q <= mag_q << 1;
				if (sh >= {1'b0, den})
					rem_q <= DW'(sh - {1'b0, den});
				else
					rem_q <= DW'(sh);
			end
			Q_FIN: res_q <= res_sat;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hdl/third_order_iir_lowpass.sv
// channel  | signals                           | payload
// ---------+-----------------------------------+-------------------------------
// in       | s_axis_tvalid/tready/tdata        | sample
// out      | m_axis_tvalid/tready/tdata        | filtered_value
// cfg      | cfg_valid/ready/index/data        | filter_select, precision_step
//
// A priming beat only shifts the sample into both histories in the back end. A
// filter beat walks the seven taps, a 16-bit operand slice at a time, through
// the single 40x17 MAC; the quantizer then runs one restoring-divide step per
// cycle for a general step and none for steps 0 and 1.0.
// A two-entry queue lets the input side take up to two beats while results stall.
// Reset clears the histories, the priming count and precision_step, and sets filter_select to 2.
`default_nettype none
`include "assert_macros.svh"

module third_order_iir_lowpass #(
	parameter int SAMPLE_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
	output logic                         m_axis_tvalid,
	input  wire logic                    m_axis_tready,
	output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]      m_axis_tdata,  // filtered_value
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic                    cfg_index,
	input  wire logic [toil_pkg::STEP_W-1:0] cfg_data
);

	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int QW     = $bits(toil_pkg::cmd_t) + SAMPLE_WIDTH;

	logic [toil_pkg::FSEL_W-1:0] fsel_q;
	logic [toil_pkg::STEP_W-1:0] pstep_q;

	toil_pkg::fifo_stat_t stat;
	toil_pkg::cmd_t       push_cmd;
	toil_pkg::cmd_t       pop_cmd;
	logic [SAMPLE_WIDTH-1:0] push_sample;
	logic [SAMPLE_WIDTH-1:0] pop_sample;
	logic [SAMPLE_WIDTH-1:0] y_data;
	logic [SAMPLE_WIDTH-1:0] out_data;
	logic push;
	logic pop;
	logic primed;
	logic y_valid;
	logic y_ready;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = DATA_W'(out_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q  <= toil_pkg::FSEL_RESET;
			pstep_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				toil_pkg::REG_FILTER_SELECT:  fsel_q  <= cfg_data[toil_pkg::FSEL_W-1:0];
				toil_pkg::REG_PRECISION_STEP: pstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	toil_front #(.SW(SAMPLE_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_sample   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.fsel        (fsel_q),
		.stat        (stat),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_sample (push_sample),
		.primed      (primed)
	);

	toil_fifo #(.W(QW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    ({push_cmd, push_sample}),
		.pop    (pop),
		.dout   ({pop_cmd, pop_sample}),
		.stat   (stat)
	);

	toil_back #(.SW(SAMPLE_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.cmd        (pop_cmd),
		.cmd_sample (pop_sample),
		.pop        (pop),
		.y_valid    (y_valid),
		.y_ready    (y_ready),
		.y_data     (y_data)
	);

	toil_quant #(.SW(SAMPLE_WIDTH)) u_quant (
		.clk       (clk),
		.arst_n    (arst_n),
		.y_valid   (y_valid),
		.y_ready   (y_ready),
		.y_data    (y_data),
		.step      (pstep_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	// no result can leave before priming is complete
	`ASSERT_PROP(a_out_after_prime, clk, arst_n, m_axis_tvalid |-> primed)
	`ASSERT_NEVER(a_fifo_stat, clk, arst_n, stat.full && stat.empty)
	`ASSERT_PROP(a_pop_needs_data, clk, arst_n, pop |-> !stat.empty)

endmodule

`default_nettype wire
